// ----- src/prc_pkg.sv -----
// Shared types and constants for the progression run offset compressor.
package prc_pkg;

	localparam int MIN_RUN_DEF  = 8;
	localparam int FLAG_BIT_DEF = 63;

	// MIN_RUN must be <= 15 (unchecked); a segment then holds <= 14 words.
	localparam int MIN_RUN_MAX = 15;
	localparam int CNT_W       = $clog2(MIN_RUN_MAX);

	localparam int WORD_W = 64;
	localparam int CFG_W  = 16;

	typedef enum logic [0:0] {
		CFG_COLUMN_DIM    = 1'b0,
		CFG_ROWS_PER_LOOP = 1'b1
	} cfg_reg_t;

	// One flushed run: words base, base+step, ... and, in marker form, the
	// marker word in place of the third word.
	typedef struct packed {
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] step;
		logic [WORD_W-1:0] mword;
		logic [CNT_W-1:0]  cnt;
		logic              mark;
		logic              fin;
	} seg_t;

endpackage

// ----- src/prc_run_tracker.sv -----
// Run state and the flush segments that each offset produces.
module prc_run_tracker #(
	parameter int MIN_RUN  = prc_pkg::MIN_RUN_DEF,
	parameter int FLAG_BIT = prc_pkg::FLAG_BIT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [prc_pkg::WORD_W-1:0] offset,
	input  logic                      is_last,
	input  logic [prc_pkg::CFG_W-1:0]  column_dim_size,
	input  logic [prc_pkg::CFG_W-1:0]  rows_per_loop,
	output prc_pkg::seg_t             seg_a,
	output prc_pkg::seg_t             seg_b
);
	import prc_pkg::*;

	localparam int LEN_W = FLAG_BIT + 1;
	localparam logic [WORD_W-1:0] FLAG_WORD = WORD_W'(1) << FLAG_BIT;
	localparam logic [WORD_W-1:0] FLAG_CAP  = FLAG_WORD + WORD_W'(1);
	localparam logic [LEN_W-1:0]  MIN_LEN   = LEN_W'(MIN_RUN);

	logic [LEN_W-1:0]  run_len_q;
	logic [WORD_W-1:0] run_step_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] head0_q;

	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] rows_cap;
	logic [WORD_W-1:0] cap;
	logic              join1;
	logic              extend;
	logic [LEN_W-1:0]  len_n;
	logic [WORD_W-1:0] step_n;
	logic [WORD_W-1:0] head0_n;

	function automatic seg_t make_seg(logic [WORD_W-1:0] base, logic [WORD_W-1:0] step,
			logic [LEN_W-1:0] len, logic fin);
		seg_t s;
		s.base  = base;
		s.step  = step;
		s.mark  = (len >= MIN_LEN);
		s.cnt   = s.mark ? CNT_W'(3) : len[CNT_W-1:0];
		s.mword = FLAG_WORD | WORD_W'(len - LEN_W'(2));
		s.fin   = fin;
		return s;
	endfunction

	always_comb begin
		diff     = offset - prev_q;
		rows_cap = (rows_per_loop < CFG_W'(2)) ? WORD_W'(2) : WORD_W'(rows_per_loop);
		cap      = (column_dim_size > CFG_W'(1) && rows_cap < FLAG_CAP) ? rows_cap : FLAG_CAP;
		join1    = (run_len_q == LEN_W'(1));
		extend   = (run_len_q >= LEN_W'(2)) && (diff == run_step_q)
			&& (WORD_W'(run_len_q) < cap);

		if (join1) begin
			head0_n = head0_q;
			step_n  = diff;
			len_n   = LEN_W'(2);
		end else if (extend) begin
			head0_n = head0_q;
			step_n  = run_step_q;
			len_n   = run_len_q + LEN_W'(1);
		end else begin
			head0_n = offset;
			step_n  = '0;
			len_n   = LEN_W'(1);
		end

		// The open run is flushed when the new offset starts a run of its own.
		seg_a = make_seg(head0_q, run_step_q, run_len_q, 1'b0);
		if (join1 || extend) begin
			seg_a.cnt = '0;
		end

		// The offset marked last flushes whatever run is open after it.
		seg_b = make_seg(head0_n, step_n, len_n, 1'b1);
		if (!is_last) begin
			seg_b.cnt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_len_q  <= '0;
			run_step_q <= '0;
			prev_q     <= '0;
		end else if (fire) begin
			run_len_q  <= is_last ? '0 : len_n;
			run_step_q <= step_n;
			prev_q     <= offset;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			head0_q <= head0_n;
		end
	end

	a_last_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last |=> run_len_q == '0)
		else $error("run left open after the last offset");

	a_single_has_no_step: assert property (@(posedge clk) disable iff (!arst_n)
		run_len_q == LEN_W'(1) |-> run_step_q == '0)
		else $error("one-element run carries a step");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last |-> seg_b.cnt != '0)
		else $error("last offset produced no final segment");

endmodule

// ----- src/prc_emitter.sv -----
// Serializes up to two flush segments into one word per handshake.
module prc_emitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  prc_pkg::seg_t              seg_a,
	input  prc_pkg::seg_t              seg_b,
	output logic                       can_load,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [prc_pkg::WORD_W-1:0] word,
	output logic                       is_marker,
	output logic                       is_final
);
	import prc_pkg::*;

	seg_t cur_q;
	seg_t pend_q;
	logic last_word;

	always_comb begin
		last_word = (cur_q.cnt == CNT_W'(1));
		out_valid = (cur_q.cnt != '0);
		is_marker = cur_q.mark && last_word;
		is_final  = cur_q.fin && last_word;
		word      = is_marker ? cur_q.mword : cur_q.base;
		can_load  = (cur_q.cnt == '0) || (last_word && pend_q.cnt == '0 && out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			pend_q <= '0;
		end else if (load) begin
			if (seg_a.cnt != '0) begin
				cur_q  <= seg_a;
				pend_q <= seg_b;
			end else begin
				cur_q      <= seg_b;
				pend_q.cnt <= '0;
			end
		end else if (out_valid && out_ready) begin
			if (last_word) begin
				cur_q      <= pend_q;
				pend_q.cnt <= '0;
			end else begin
				cur_q.cnt  <= cur_q.cnt - CNT_W'(1);
				cur_q.base <= cur_q.base + cur_q.step;
			end
		end
	end

	a_pend_behind_cur: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q.cnt != '0 |-> cur_q.cnt != '0)
		else $error("queued segment with nothing being sent");

	a_final_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_final |-> pend_q.cnt == '0)
		else $error("final word sent ahead of queued words");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load && (seg_a.cnt != '0 || seg_b.cnt != '0) |=> out_valid)
		else $error("loaded segment did not reach the output");

endmodule

// ----- src/progression_run_offset_compressor.sv -----
// Top level of the progression run offset compressor.
//
// Offsets enter on the in channel (offset, is_last) one word per handshake
// and are cut into arithmetic runs. Results leave on the out channel as
// words: raw offsets, or for a run of at least MIN_RUN elements its first
// two offsets followed by a marker word (is_marker high) holding the flag
// bit and the run length minus two. is_final marks the last word of a list.
// The cfg channel writes column_dim_size (index 0) and rows_per_loop
// (index 1); it is always ready. It must be written by the user only while
// the block idles; the block itself does not enforce this. An accepted
// offset lands in an input register; once the emitter can take the result,
// the run tracker updates the run and hands any flushed run to the emitter,
// whose register drives the out channel. With the emitter idle, or on its
// last word with nothing queued and the receiver ready, offsets that only
// extend a run flow in at one per cycle. An offset that flushes words holds
// intake until the emitter is on the last of them, even with the receiver
// always ready, since the emitter sends one word per cycle.
// Reset clears the open run, the registers go to column_dim_size = 1 and
// rows_per_loop = 65535, and no word is pending. When the receiver stalls,
// the current word holds and intake stops once the input register fills.
module progression_run_offset_compressor #(
	parameter int MIN_RUN  = prc_pkg::MIN_RUN_DEF,
	parameter int FLAG_BIT = prc_pkg::FLAG_BIT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [prc_pkg::WORD_W-1:0] offset,
	input  logic                       is_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [prc_pkg::WORD_W-1:0] word,
	output logic                       is_marker,
	output logic                       is_final,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  prc_pkg::cfg_reg_t          cfg_index,
	input  logic [prc_pkg::CFG_W-1:0]  cfg_data
);
	import prc_pkg::*;

	logic              valid_s1;
	logic [WORD_W-1:0] offset_s1;
	logic              is_last_s1;

	logic [CFG_W-1:0] column_dim_size_q;
	logic [CFG_W-1:0] rows_per_loop_q;

	logic can_load;
	logic fire;
	seg_t seg_a;
	seg_t seg_b;

	// The input register moves on whenever the emitter can take what the
	// tracker produces from it.
	assign fire      = valid_s1 && can_load;
	assign in_ready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			offset_s1  <= offset;
			is_last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_dim_size_q <= CFG_W'(1);
			rows_per_loop_q   <= CFG_W'(65535);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_COLUMN_DIM: begin
					column_dim_size_q <= cfg_data;
				end
				CFG_ROWS_PER_LOOP: begin
					rows_per_loop_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	prc_run_tracker #(
		.MIN_RUN  (MIN_RUN),
		.FLAG_BIT (FLAG_BIT)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.fire            (fire),
		.offset          (offset_s1),
		.is_last         (is_last_s1),
		.column_dim_size (column_dim_size_q),
		.rows_per_loop   (rows_per_loop_q),
		.seg_a           (seg_a),
		.seg_b           (seg_b)
	);

	prc_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.seg_a     (seg_a),
		.seg_b     (seg_b),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.is_marker (is_marker),
		.is_final  (is_final)
	);

endmodule
